[hdl/bia_pkg.sv]
// bia_pkg: shared types and constants for the block and inode allocator
// no dependencies; imported by bia_cfg and block_and_inode_allocator
package bia_pkg;

	localparam int CMD_W = 3;
	localparam int ID_W = 16;
	localparam int NBLK_W = 10;
	localparam int STAT_W = 2;
	localparam int RSV_W = 10;
	localparam int BSZ_W = 4;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 10;

	localparam logic [CMD_W-1:0] CMD_FORMAT = 3'd0;
	localparam logic [CMD_W-1:0] CMD_ALLOC_BLK = 3'd1;
	localparam logic [CMD_W-1:0] CMD_FREE_BLK = 3'd2;
	localparam logic [CMD_W-1:0] CMD_ALLOC_INO = 3'd3;
	localparam logic [CMD_W-1:0] CMD_FREE_INO = 3'd4;

	localparam logic [STAT_W-1:0] ST_OK = 2'd0;
	localparam logic [STAT_W-1:0] ST_EXHAUSTED = 2'd1;
	localparam logic [STAT_W-1:0] ST_INVALID = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_RESERVED = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_BLKSZ = 1'b1;

	localparam logic [BSZ_W-1:0] INODE_LOG2 = 4'd6;
	localparam logic [BSZ_W-1:0] RESET_BLKSZ = 4'd12;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic [ID_W-1:0]  target_id;
	} req_t;

	typedef struct packed {
		logic [ID_W-1:0]   result_id;
		logic [NBLK_W-1:0] new_block;
		logic              block_taken;
		logic [STAT_W-1:0] status;
	} rsp_t;

	typedef struct packed {
		logic [RSV_W-1:0] reserved_blocks;
		logic [BSZ_W-1:0] block_size_log2;
	} cfg_t;

endpackage

[hdl/bia_ram.sv]
// bia_ram: single-port-write, single-port-read memory with registered read data
// used for the block and inode link tables; no package dependencies
module bia_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 10
) (
	input  logic                     clk,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[hdl/bia_cfg.sv]
// bia_cfg: configuration registers (reserved block count, block size)
// depends on bia_pkg
module bia_cfg
	import bia_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reserved_blocks <= '0;
			cfg_q.block_size_log2 <= RESET_BLKSZ;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_RESERVED: cfg_q.reserved_blocks <= cfg_data[RSV_W-1:0];
				CFG_BLKSZ:    cfg_q.block_size_log2 <= cfg_data[BSZ_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

[hdl/block_and_inode_allocator.sv]
// block_and_inode_allocator: top level, free-list and bump-pointer allocator
// depends on bia_pkg, bia_ram, bia_cfg
//
//   channel | handshake                 | payload
//   --------+---------------------------+-----------------------------
//   request | start, busy               | req (cmd, target_id)
//   result  | done (one-cycle strobe)   | rsp (result_id, new_block, ...)
//   config  | cfg_valid, cfg_ready      | cfg_index, cfg_data
//
// on every request the link memories are read at acceptance
// and the heads and pointers are updated in the following execute cycle
// the result strobe follows in the cycle after execute, when busy is already low
// a new request can be accepted in the same cycle as the previous result
// the receiver cannot stall; start is held off only while busy is high
// after reset the heads are empty, next block is one, registers hold defaults
module block_and_inode_allocator
	import bia_pkg::*;
#(
	parameter int NUM_BLOCKS = 1024,
	parameter int INODE_ID_SPACE = 65536
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  req_t                  req,
	output logic                  done,
	output rsp_t                  rsp,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int BW = $clog2(NUM_BLOCKS);
	localparam int NBW = (BW + 1 > RSV_W + 1) ? BW + 1 : RSV_W + 1;
	localparam int IW = $clog2(INODE_ID_SPACE);
	localparam int NIW = IW + 1;

	localparam logic S_IDLE = 1'b0;
	localparam logic S_EXEC = 1'b1;

	cfg_t cfg;

	logic state_q;
	logic [CMD_W-1:0] cmd_s1;
	logic [ID_W-1:0] tid_s1;
	logic [BW-1:0] fbh_q, fbh_d;
	logic [NBW-1:0] nb_q, nb_d;
	logic [IW-1:0] fih_q, fih_d;
	logic [NIW-1:0] ni_q, ni_d;
	rsp_t rsp_q, rsp_d;
	logic done_q;

	logic accept;
	logic [BW-1:0] blk_rdata;
	logic [IW-1:0] ino_rdata;
	logic blk_we, ino_we;
	logic take;

	logic [31:0] tid32, fbh32, nb32, ni32, peek32, first32, per32, cur32, ninc32, rsv32;
	logic peek_ok, room_ok, ni_wrap;
	logic [BSZ_W-1:0] sh;

	bia_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	bia_ram #(.DEPTH(NUM_BLOCKS), .WIDTH(BW)) u_blk_links (
		.clk   (clk),
		.re    (accept),
		.raddr (fbh_q),
		.rdata (blk_rdata),
		.we    (blk_we),
		.waddr (tid32[BW-1:0]),
		.wdata (fbh_q)
	);

	bia_ram #(.DEPTH(INODE_ID_SPACE), .WIDTH(IW)) u_ino_links (
		.clk   (clk),
		.re    (accept),
		.raddr (fih_q),
		.rdata (ino_rdata),
		.we    (ino_we),
		.waddr (tid32[IW-1:0]),
		.wdata (fih_q)
	);

	assign busy = (state_q == S_EXEC);
	assign accept = start && !busy;
	assign done = done_q;
	assign rsp = rsp_q;

	// block peek, inode carving geometry
	always_comb begin
		tid32 = 32'(tid_s1);
		fbh32 = 32'(fbh_q);
		nb32 = 32'(nb_q);
		ni32 = 32'(ni_q);
		rsv32 = 32'(cfg.reserved_blocks) + 32'd1;
		peek_ok = (fbh_q != '0) || (nb32 < NUM_BLOCKS);
		if (fbh_q != '0) begin
			peek32 = fbh32;
		end else if (nb32 < NUM_BLOCKS) begin
			peek32 = nb32;
		end else begin
			peek32 = '0;
		end
		sh = (cfg.block_size_log2 < INODE_LOG2) ? '0 : cfg.block_size_log2 - INODE_LOG2;
		per32 = 32'd1 << sh;
		first32 = peek32 << sh;
		room_ok = (first32 + per32) <= INODE_ID_SPACE;
		cur32 = (ni_q == '0) ? first32 : ni32;
		ninc32 = cur32 + 32'd1;
		ni_wrap = (ninc32 & (per32 - 32'd1)) == '0;
	end

	always_comb begin
		fbh_d = fbh_q;
		nb_d = nb_q;
		fih_d = fih_q;
		ni_d = ni_q;
		rsp_d = '0;
		blk_we = 1'b0;
		ino_we = 1'b0;
		take = 1'b0;
		if (state_q == S_EXEC) begin
			unique case (cmd_s1)
				CMD_FORMAT: begin
					fbh_d = '0;
					nb_d = rsv32[NBW-1:0];
					fih_d = '0;
					ni_d = '0;
				end
				CMD_ALLOC_BLK: begin
					if (peek_ok) begin
						rsp_d.result_id = peek32[ID_W-1:0];
						take = 1'b1;
					end else begin
						rsp_d.status = ST_EXHAUSTED;
					end
				end
				CMD_FREE_BLK: begin
					if (tid32 == '0 || tid32 >= NUM_BLOCKS) begin
						rsp_d.status = ST_INVALID;
					end else begin
						blk_we = 1'b1;
						fbh_d = tid32[BW-1:0];
					end
				end
				CMD_ALLOC_INO: begin
					if (fih_q != '0) begin
						rsp_d.result_id = ID_W'(32'(fih_q));
						fih_d = ino_rdata;
					end else if (ni_q == '0 && (!peek_ok || !room_ok)) begin
						rsp_d.status = ST_EXHAUSTED;
					end else begin
						if (ni_q == '0) begin
							take = 1'b1;
							rsp_d.new_block = peek32[NBLK_W-1:0];
							rsp_d.block_taken = 1'b1;
						end
						rsp_d.result_id = cur32[ID_W-1:0];
						ni_d = ni_wrap ? '0 : ninc32[NIW-1:0];
					end
				end
				CMD_FREE_INO: begin
					if (tid32 == '0 || tid32 >= INODE_ID_SPACE) begin
						rsp_d.status = ST_INVALID;
					end else begin
						ino_we = 1'b1;
						fih_d = tid32[IW-1:0];
					end
				end
				default: ;
			endcase
			if (take) begin
				if (fbh_q != '0) begin
					fbh_d = blk_rdata;
				end else begin
					nb_d = nb_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q <= 1'b0;
			fbh_q <= '0;
			nb_q <= NBW'(1);
			fih_q <= '0;
			ni_q <= '0;
		end else begin
			fbh_q <= fbh_d;
			nb_q <= nb_d;
			fih_q <= fih_d;
			ni_q <= ni_d;
			done_q <= (state_q == S_EXEC);
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= req.cmd;
			tid_s1 <= req.target_id;
		end
		if (state_q == S_EXEC) begin
			rsp_q <= rsp_d;
		end
	end

	a_exec_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !busy) else $error("execute lasted more than one cycle");

	a_accept_starts_exec: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy) else $error("accepted request not executed");

	a_done_after_exec: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("result without an executed request");

	a_fail_no_id: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.status != ST_OK |-> rsp.result_id == '0 && !rsp.block_taken)
		else $error("failed request returned an id");

	a_taken_is_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.block_taken |-> rsp.status == ST_OK && rsp.result_id != '0)
		else $error("block taken on a failed inode allocation");

endmodule
